// ----- hdl/utf8_to_latin1_code_decoder_macros.svh -----
// Assertion macros for the checker file of the UTF-8 decoder.
// No dependencies; include by bare file name.
`ifndef UTF8_TO_LATIN1_CODE_DECODER_MACROS_SVH
`define UTF8_TO_LATIN1_CODE_DECODER_MACROS_SVH

// Check a property while out of reset.
`define U2L_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Check a property at every edge, reset included.
`define U2L_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ----- hdl/u2l_pkg.sv -----
// Package for the UTF-8 to single-byte code decoder.
// Holds the queue entry type, byte class constants and the code mapping.
package u2l_pkg;

  localparam int unsigned MAX_LEN_DEF = 256;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] EURO_POINT  = 16'h20AC;
  localparam logic [15:0] LATIN_MAX   = 16'h00FF;
  localparam logic [7:0]  EURO_CODE   = 8'h80;
  localparam logic [7:0]  SUBST_CODE  = 8'hB7;
  localparam logic [7:0]  ASCII_MAX   = 8'h7F;
  localparam logic [7:0]  CONT_MAX    = 8'hBF;
  localparam logic [7:0]  LEAD2_MAX   = 8'hDF;
  localparam logic [7:0]  LEAD3_MAX   = 8'hEF;
  localparam logic [1:0]  CONT_TAG    = 2'b10;

  // One queue entry: an optional character result followed by an optional
  // terminator result. Every pushed entry carries at least one of them.
  typedef struct packed {
    logic       has_char;
    logic [7:0] char_code;
    logic [7:0] char_pos;
    logic       has_end;
    logic [7:0] end_pos;
  } u2l_entry_t;

  function automatic logic [7:0] map_code(input logic [15:0] v);
    logic [7:0] res;
    if (v == EURO_POINT) begin
      res = EURO_CODE;
    end else if (v > LATIN_MAX) begin
      res = SUBST_CODE;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

// ----- hdl/u2l_front.sv -----
// Front end: accepts bytes, tracks the accumulator and counters, and builds
// queue entries for the results each byte causes. Depends on u2l_pkg.
module u2l_front #(
  parameter int unsigned MaxLen = u2l_pkg::MAX_LEN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  output logic                push_o,
  output u2l_pkg::u2l_entry_t entry_o
);
  import u2l_pkg::*;

  localparam int unsigned CntW = $clog2(MaxLen);
  localparam logic [CntW-1:0] LastCnt = CntW'(MaxLen - 1);

  logic [15:0]     acc_q, acc_d;
  logic            pending_q, pending_d;
  logic [7:0]      out_cnt_q, out_cnt_d;
  logic [CntW-1:0] in_cnt_q, in_cnt_d;
  logic            is_zero, is_cont, flush;

  assign is_zero = (in_byte_i == 8'h00);
  assign is_cont = (in_byte_i[7:6] == CONT_TAG);
  assign flush   = pending_q && !is_cont;

  always_comb begin
    acc_d             = acc_q;
    pending_d         = pending_q;
    out_cnt_d         = out_cnt_q;
    in_cnt_d          = in_cnt_q;
    push_o            = 1'b0;
    entry_o.has_char  = 1'b0;
    entry_o.char_code = map_code(acc_q);
    entry_o.char_pos  = out_cnt_q;
    entry_o.has_end   = 1'b0;
    entry_o.end_pos   = out_cnt_q + 8'(pending_q);
    if (accept_i) begin
      priority if (is_zero) begin
        // flush any pending character, then terminate and restart
        push_o           = 1'b1;
        entry_o.has_char = pending_q;
        entry_o.has_end  = 1'b1;
        acc_d            = '0;
        pending_d        = 1'b0;
        out_cnt_d        = '0;
        in_cnt_d         = '0;
      end else if (in_cnt_q >= LastCnt) begin
        // drop bytes beyond the length limit
      end else begin
        in_cnt_d         = in_cnt_q + 1'b1;
        push_o           = flush;
        entry_o.has_char = flush;
        out_cnt_d        = out_cnt_q + 8'(flush);
        pending_d        = 1'b1;
        priority if (in_byte_i <= ASCII_MAX) begin
          acc_d = {8'h00, in_byte_i};
        end else if (in_byte_i <= CONT_MAX) begin
          acc_d = {acc_q[9:0], in_byte_i[5:0]};
        end else if (in_byte_i <= LEAD2_MAX) begin
          acc_d = {11'h000, in_byte_i[4:0]};
        end else if (in_byte_i <= LEAD3_MAX) begin
          acc_d = {12'h000, in_byte_i[3:0]};
        end else begin
          acc_d = {13'h0000, in_byte_i[2:0]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      pending_q <= 1'b0;
      out_cnt_q <= '0;
      in_cnt_q  <= '0;
    end else begin
      acc_q     <= acc_d;
      pending_q <= pending_d;
      out_cnt_q <= out_cnt_d;
      in_cnt_q  <= in_cnt_d;
    end
  end

endmodule

// ----- hdl/u2l_queue.sv -----
// Short FIFO of result entries between the front end and the output stage.
// Depends on u2l_pkg for the entry type and depth.
module u2l_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  u2l_pkg::u2l_entry_t entry_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output u2l_pkg::u2l_entry_t head_o
);
  import u2l_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  u2l_entry_t      mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

// ----- hdl/u2l_back.sv -----
// Output stage: presents the head entry as one or two result transactions.
// Depends on u2l_pkg for the entry type.
module u2l_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  u2l_pkg::u2l_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          code_o,
  output logic                is_end_o,
  output logic [7:0]          position_o
);
  import u2l_pkg::*;

  logic phase_q, phase_d;
  logic show_char, last, fire;

  // phase_q set means the character half of the head entry is already gone
  assign show_char   = head_i.has_char && !phase_q;
  assign last        = !(show_char && head_i.has_end);
  assign out_valid_o = head_valid_i;
  assign fire        = head_valid_i && out_ready_i;
  assign pop_o       = fire && last;
  assign code_o      = show_char ? head_i.char_code : 8'h00;
  assign is_end_o    = !show_char;
  assign position_o  = show_char ? head_i.char_pos : head_i.end_pos;

  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      phase_d = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// ----- hdl/utf8_to_latin1_code_decoder.sv -----
// Top level of the UTF-8 to single-byte code decoder.
// Instantiates u2l_front, u2l_queue and u2l_back; depends on u2l_pkg.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------
//   in      | in_valid_i/in_ready_o | in_byte_i[7:0]
//   out     | out_valid_o/out_ready_i | code_o[7:0] is_end_o position_o[7:0]
//
// One byte is taken per cycle unless the queue is full; results are queued.
// A zero byte with a pending character yields two results, output as two
// transactions; the four-entry queue absorbs this; input stalls only if full.
// in_ready_o drops only when the queue is full; output stalls back up there.
// Reset (asynchronous, active low) clears the counters, accumulator and queue.
module utf8_to_latin1_code_decoder #(
  parameter int unsigned MaxLen = u2l_pkg::MAX_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] code_o,
  output logic       is_end_o,
  output logic [7:0] position_o
);
  import u2l_pkg::*;

  u2l_entry_t entry, head;
  logic       push, pop, full, head_valid, accept;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  u2l_front #(
    .MaxLen(MaxLen)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_byte_i(in_byte_i),
    .push_o   (push),
    .entry_o  (entry)
  );

  u2l_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .full_o (full),
    .valid_o(head_valid),
    .head_o (head)
  );

  u2l_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_o      (code_o),
    .is_end_o    (is_end_o),
    .position_o  (position_o)
  );

endmodule

// ----- hdl/u2l_checker.sv -----
// Port-level checker for the UTF-8 decoder, bound to the top level.
// Depends on utf8_to_latin1_code_decoder_macros.svh.
module u2l_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] code_o,
  input logic       is_end_o,
  input logic [7:0] position_o
);
`include "utf8_to_latin1_code_decoder_macros.svh"

  logic out_stall;
  logic in_stall;

  assign out_stall = out_valid_o && !out_ready_i;
  assign in_stall  = in_valid_i && !in_ready_o;

  // hold a stalled transaction
  `U2L_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(position_o))
  // hold a waiting input transaction
  `U2L_ASSERT(a_in_hold, clk_i, rst_ni, in_stall |=> in_valid_i && $stable(in_byte_i))
  // terminator results carry code zero
  `U2L_ASSERT(a_end_code, clk_i, rst_ni, out_valid_o && is_end_o |-> code_o == 8'h00)
  // nothing is offered while in reset
  `U2L_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |-> !out_valid_o)

endmodule

bind utf8_to_latin1_code_decoder u2l_checker u_chk (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench for utf8_to_latin1_code_decoder.
// Drives UTF-8 byte strings, predicts the decoded codes and compares each output transaction.
// Depends only on the RTL under hdl/.
module testbench;

  localparam int unsigned STR_MAX     = 256;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 16;
  localparam int unsigned RANDOM_ITEMS = 370;

  localparam logic [7:0]  STR_END    = 8'h00;
  localparam logic [7:0]  ASCII_TOP  = 8'h7F;
  localparam logic [7:0]  CONT_TOP   = 8'hBF;
  localparam logic [7:0]  LEAD2_TOP  = 8'hDF;
  localparam logic [7:0]  LEAD3_TOP  = 8'hEF;
  localparam logic [1:0]  CONT_MARK  = 2'b10;
  localparam logic [15:0] EURO_CP    = 16'h20AC;
  localparam logic [15:0] LATIN1_TOP = 16'h00FF;
  localparam logic [7:0]  EURO_BYTE  = 8'h80;
  localparam logic [7:0]  MIDDOT     = 8'hB7;

  typedef struct packed {
    logic [7:0] code;
    logic       is_end;
    logic [7:0] position;
  } code_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b1;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] code_o;
  logic       is_end_o;
  logic [7:0] position_o;

  // Decoder state mirror
  logic [15:0] cp_acc    = '0;
  logic        char_open = 1'b0;
  logic [7:0]  codes_out = '0;
  int unsigned bytes_in  = 0;

  code_result_t decoded_codes_q[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  items_sent     = 0;
  bit           in_idle_en     = 1'b1;
  bit           out_idle_en    = 1'b1;
  int unsigned  out_stall      = 0;

  utf8_to_latin1_code_decoder #(
    .MaxLen(STR_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .code_o     (code_o),
    .is_end_o   (is_end_o),
    .position_o (position_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] to_latin1(input logic [15:0] cp);
    logic [7:0] res;
    if (cp == EURO_CP) begin
      res = EURO_BYTE;
    end else if (cp > LATIN1_TOP) begin
      res = MIDDOT;
    end else begin
      res = cp[7:0];
    end
    return res;
  endfunction

  task automatic push_code(input logic [7:0] code, input logic is_end, input logic [7:0] pos);
    code_result_t r;
    r.code     = code;
    r.is_end   = is_end;
    r.position = pos;
    decoded_codes_q.push_back(r);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    if (b == STR_END) begin
      if (char_open) begin
        push_code(to_latin1(cp_acc), 1'b0, codes_out);
        codes_out = codes_out + 8'd1;
      end
      push_code(8'h00, 1'b1, codes_out);
      cp_acc    = '0;
      char_open = 1'b0;
      codes_out = '0;
      bytes_in  = 0;
    end else if (bytes_in < STR_MAX - 1) begin
      bytes_in++;
      // Flush the open character on any byte that is not a continuation
      if (char_open && b[7:6] != CONT_MARK) begin
        push_code(to_latin1(cp_acc), 1'b0, codes_out);
        codes_out = codes_out + 8'd1;
      end
      if (b <= ASCII_TOP) begin
        cp_acc = {8'h00, b};
      end else if (b <= CONT_TOP) begin
        cp_acc = {cp_acc[9:0], b[5:0]};
      end else if (b <= LEAD2_TOP) begin
        cp_acc = {11'h000, b[4:0]};
      end else if (b <= LEAD3_TOP) begin
        cp_acc = {12'h000, b[3:0]};
      end else begin
        cp_acc = {13'h0000, b[2:0]};
      end
      char_open = 1'b1;
    end
  endtask

  // Enter and leave at a falling edge; valid stays high after the transaction.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    decode_byte(b);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic stop_input();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_cont(input int unsigned n);
    repeat (n) send_byte({CONT_MARK, 6'($urandom_range(0, 63))});
  endtask

  // One character: mostly well-formed sequences, some stray or random bytes
  task automatic send_random_char();
    case ($urandom_range(0, 11))
      0, 1, 2, 3: send_byte(8'($urandom_range(1, 127)));
      4, 5: begin
        send_byte({3'b110, 5'($urandom_range(0, 31))});
        send_cont(1);
      end
      6: begin
        send_byte({4'b1110, 4'($urandom_range(0, 15))});
        send_cont(2);
      end
      7: begin
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'hAC);
      end
      8: begin
        send_byte({5'b11110, 3'($urandom_range(0, 7))});
        send_cont(3);
      end
      9: begin
        // truncated sequence
        send_byte({4'b1110, 4'($urandom_range(0, 15))});
        send_cont(1);
      end
      10: send_cont($urandom_range(1, 4));
      default: send_byte(8'($urandom_range(1, 255)));
    endcase
  endtask

  task automatic send_random_string(input int unsigned max_chars);
    int unsigned n;
    n = $urandom_range(0, max_chars);
    repeat (n) send_random_char();
    send_byte(STR_END);
  endtask

  task automatic test_directed();
    send_byte(STR_END);                     // empty string
    send_byte(8'h9F);                       // continuation at the start of a string
    send_byte(8'h41);
    send_byte(STR_END);
    send_byte(8'hC3); send_byte(8'hA9);     // two-byte, fits in one byte
    send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);  // euro sign
    send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAD);  // above 0xFF
    send_byte(8'hF7); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(8'hDF); send_byte(8'h80);
    send_byte(8'hEF);
    send_byte(STR_END);
    stop_input();
  endtask

  // More than STR_MAX-1 bytes: the tail is dropped, the zero still ends it
  task automatic test_overlong();
    repeat (STR_MAX + 4) send_byte(8'($urandom_range(1, 255)));
    send_byte(STR_END);
    stop_input();
  endtask

  task automatic test_random_strings();
    while (items_sent < RANDOM_ITEMS) begin
      send_random_string(16);
    end
    stop_input();
  endtask

  task automatic test_back_to_back();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    repeat (6) send_random_string(10);
    stop_input();
  endtask

  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_stall   <= out_stall - 1;
      out_ready_i <= 1'b0;
    end else if (out_idle_en && $urandom_range(0, 4) == 0) begin
      out_stall   <= $urandom_range(0, 7);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    code_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_codes_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got code %h is_end %b position %0d",
                 $time, code_o, is_end_o, position_o);
        mismatch_count++;
      end else begin
        want = decoded_codes_q.pop_front();
        if (code_o !== want.code) begin
          $display("%0t: code expected %h, actual %h", $time, want.code, code_o);
          mismatch_count++;
        end
        if (is_end_o !== want.is_end) begin
          $display("%0t: is_end expected %b, actual %b", $time, want.is_end, is_end_o);
          mismatch_count++;
        end
        if (position_o !== want.position) begin
          $display("%0t: position expected %0d, actual %0d", $time, want.position, position_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d transactions outstanding", $time, decoded_codes_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_overlong();
    test_random_strings();
    test_back_to_back();

    while (decoded_codes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/u2l_pkg.sv
hdl/u2l_front.sv
hdl/u2l_queue.sv
hdl/u2l_back.sv
hdl/utf8_to_latin1_code_decoder.sv
hdl/u2l_checker.sv
dv/testbench.sv
